FILE: rtl/csvs_pkg.sv
// shared types and codes of the csv cell and row boundary scanner
package csvs_pkg;

	localparam int unsigned CHAR_WIDTH  = 8;
	localparam int unsigned INDEX_WIDTH = 3;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [INDEX_WIDTH-1:0] REG_CSV_MODE  = 3'd0;
	localparam logic [INDEX_WIDTH-1:0] REG_QUOTE     = 3'd1;
	localparam logic [INDEX_WIDTH-1:0] REG_ESCAPE    = 3'd2;
	localparam logic [INDEX_WIDTH-1:0] REG_SEPARATOR = 3'd3;
	localparam logic [INDEX_WIDTH-1:0] REG_NEWLINE   = 3'd4;

	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam logic REC_CELL = 1'b0;
	localparam logic REC_ROW  = 1'b1;

	localparam logic [CHAR_WIDTH-1:0] RESET_QUOTE     = 8'd34;
	localparam logic [CHAR_WIDTH-1:0] RESET_ESCAPE    = 8'd92;
	localparam logic [CHAR_WIDTH-1:0] RESET_SEPARATOR = 8'd44;
	localparam logic [CHAR_WIDTH-1:0] RESET_NEWLINE   = 8'd10;

	typedef struct packed {
		logic                  csv_mode;
		logic [CHAR_WIDTH-1:0] quote_char;
		logic [CHAR_WIDTH-1:0] escape_char;
		logic [CHAR_WIDTH-1:0] separator_char;
		logic [CHAR_WIDTH-1:0] newline_char;
	} cfg_t;

endpackage

FILE: rtl/csvs_front.sv
// front end: takes input words, tracks scan state and queues boundary entries
module csvs_front #(
	parameter int unsigned OFFSET_WIDTH = 32,
	parameter int unsigned COUNT_WIDTH  = 16,
	parameter int unsigned ENTRY_WIDTH  = 1 + 3 * OFFSET_WIDTH + COUNT_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  csvs_pkg::cfg_t                       cfg,
	input  logic                                 accept,
	input  logic                                 kind,
	input  logic [csvs_pkg::CHAR_WIDTH-1:0]      data_byte,
	output logic                                 push,
	output logic [ENTRY_WIDTH-1:0]               entry
);

	logic [OFFSET_WIDTH-1:0] byte_position_q, cell_begin_q, row_begin_q;
	logic [COUNT_WIDTH-1:0]  row_cell_tally_q;
	logic                    escape_pending_q, inside_quotes_q;

	logic [OFFSET_WIDTH-1:0] pos_next, cell_next, row_next, pos_inc;
	logic [COUNT_WIDTH-1:0]  tally_next, tally_inc;
	logic                    esc_next, quote_next, two_recs, done;

	assign pos_inc   = byte_position_q + OFFSET_WIDTH'(1);
	assign tally_inc = (row_cell_tally_q == {COUNT_WIDTH{1'b1}}) ?
		row_cell_tally_q : row_cell_tally_q + COUNT_WIDTH'(1);

	always_comb begin
		pos_next   = byte_position_q;
		cell_next  = cell_begin_q;
		row_next   = row_begin_q;
		tally_next = row_cell_tally_q;
		esc_next   = escape_pending_q;
		quote_next = inside_quotes_q;
		push       = 1'b0;
		two_recs   = 1'b0;
		done       = 1'b0;
		if (accept) begin
			if (kind == csvs_pkg::KIND_FLUSH) begin
				if (cell_begin_q < byte_position_q && row_cell_tally_q != '0) begin
					push       = 1'b1;
					two_recs   = 1'b1;
					tally_next = '0;
					row_next   = byte_position_q;
					cell_next  = byte_position_q;
				end
			end else begin
				if (cfg.csv_mode) begin
					if (escape_pending_q) begin
						esc_next = 1'b0;
						done     = 1'b1;
					end else if (inside_quotes_q) begin
						if (data_byte == cfg.quote_char) quote_next = 1'b0;
						done = 1'b1;
					end else begin
						if (data_byte == cfg.escape_char) esc_next = 1'b1;
						if (data_byte == cfg.quote_char) quote_next = 1'b1;
						if (data_byte == cfg.separator_char &&
							data_byte != cfg.newline_char) begin
							push       = 1'b1;
							tally_next = tally_inc;
							cell_next  = pos_inc;
						end
					end
				end
				if (!done && data_byte == cfg.newline_char) begin
					if (row_begin_q != byte_position_q) begin
						push     = 1'b1;
						two_recs = 1'b1;
					end
					tally_next = '0;
					cell_next  = pos_inc;
					row_next   = pos_inc;
				end
				pos_next = pos_inc;
			end
		end
	end

	assign entry = {two_recs, cell_begin_q, byte_position_q, row_begin_q, tally_inc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			cell_begin_q     <= '0;
			row_begin_q      <= '0;
			row_cell_tally_q <= '0;
			escape_pending_q <= 1'b0;
			inside_quotes_q  <= 1'b0;
		end else begin
			byte_position_q  <= pos_next;
			cell_begin_q     <= cell_next;
			row_begin_q      <= row_next;
			row_cell_tally_q <= tally_next;
			escape_pending_q <= esc_next;
			inside_quotes_q  <= quote_next;
		end
	end

endmodule

FILE: rtl/csvs_queue.sv
// short register queue between the front end and the record emitter
module csvs_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

FILE: rtl/csvs_back.sv
// back end: turns queued entries into cell and row records on the output register
module csvs_back #(
	parameter int unsigned OFFSET_WIDTH = 32,
	parameter int unsigned COUNT_WIDTH  = 16,
	parameter int unsigned ENTRY_WIDTH  = 1 + 3 * OFFSET_WIDTH + COUNT_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [ENTRY_WIDTH-1:0]  head,
	input  logic                    empty,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    record_kind,
	output logic [OFFSET_WIDTH-1:0] start_offset,
	output logic [OFFSET_WIDTH-1:0] end_offset,
	output logic [COUNT_WIDTH-1:0]  cells_in_row,
	output logic                    last
);

	logic                    two_recs;
	logic [OFFSET_WIDTH-1:0] cell_start, rec_end, row_start;
	logic [COUNT_WIDTH-1:0]  count;
	logic                    load, phase_q, valid_q, kind_q, last_q;
	logic [OFFSET_WIDTH-1:0] start_q, end_q;
	logic [COUNT_WIDTH-1:0]  count_q;

	assign {two_recs, cell_start, rec_end, row_start, count} = head;

	assign load = (!valid_q || out_ready) && !empty;
	assign pop  = load && (!two_recs || phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			phase_q <= two_recs && !phase_q;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			end_q <= rec_end;
			if (two_recs && phase_q) begin
				kind_q  <= csvs_pkg::REC_ROW;
				start_q <= row_start;
				count_q <= count;
				last_q  <= 1'b1;
			end else begin
				kind_q  <= csvs_pkg::REC_CELL;
				start_q <= cell_start;
				count_q <= '0;
				last_q  <= !two_recs;
			end
		end
	end

	assign out_valid    = valid_q;
	assign record_kind  = kind_q;
	assign start_offset = start_q;
	assign end_offset   = end_q;
	assign cells_in_row = count_q;
	assign last         = last_q;

endmodule

FILE: rtl/csv_cell_row_boundary_scanner.sv
// top level of the csv cell and row boundary scanner
// usage:
//   input channel (in_valid/in_ready, kind, data_byte) takes one word per cycle
//   while in_ready is high: a data byte, or an end-of-input flush that closes a
//   row once it has passed a separator and holds an open non-empty cell
//   output channel (out_valid/out_ready) gives cell and row records with byte
//   offsets; last marks the final record caused by one input word
//   configuration is written through cfg_wr_en/cfg_index/cfg_data while idle
// throughput: one input word per cycle while in_ready is high; the record emitter
//   gives one record per cycle while out_ready is high, so a row end (cell plus
//   row record) is a burst that a four-entry queue between scanner and emitter
//   absorbs; a long run of input that needs more than one record per word then
//   holds in_ready low while the queue is full
// reset: all offsets, counts and quote/escape state clear; registers return
//   to csv mode with quote 34, escape 92, separator 44, newline 10
// stall: with out_ready low the output record holds; the queue fills and
//   in_ready drops when it is full, without losing a word
module csv_cell_row_boundary_scanner #(
	parameter int unsigned OFFSET_WIDTH = 32,
	parameter int unsigned COUNT_WIDTH  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [csvs_pkg::INDEX_WIDTH-1:0]     cfg_index,
	input  logic [csvs_pkg::CHAR_WIDTH-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 kind,
	input  logic [csvs_pkg::CHAR_WIDTH-1:0]      data_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 record_kind,
	output logic [OFFSET_WIDTH-1:0]              start_offset,
	output logic [OFFSET_WIDTH-1:0]              end_offset,
	output logic [COUNT_WIDTH-1:0]               cells_in_row,
	output logic                                 last
);

	localparam int unsigned ENTRY_WIDTH = 1 + 3 * OFFSET_WIDTH + COUNT_WIDTH;

	csvs_pkg::cfg_t         cfg_q;
	logic                   accept, push, pop, full, empty;
	logic [ENTRY_WIDTH-1:0] entry, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.csv_mode       <= 1'b1;
			cfg_q.quote_char     <= csvs_pkg::RESET_QUOTE;
			cfg_q.escape_char    <= csvs_pkg::RESET_ESCAPE;
			cfg_q.separator_char <= csvs_pkg::RESET_SEPARATOR;
			cfg_q.newline_char   <= csvs_pkg::RESET_NEWLINE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				csvs_pkg::REG_CSV_MODE:  cfg_q.csv_mode       <= cfg_data[0];
				csvs_pkg::REG_QUOTE:     cfg_q.quote_char     <= cfg_data;
				csvs_pkg::REG_ESCAPE:    cfg_q.escape_char    <= cfg_data;
				csvs_pkg::REG_SEPARATOR: cfg_q.separator_char <= cfg_data;
				csvs_pkg::REG_NEWLINE:   cfg_q.newline_char   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	csvs_front #(
		.OFFSET_WIDTH (OFFSET_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH),
		.ENTRY_WIDTH  (ENTRY_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.kind      (kind),
		.data_byte (data_byte),
		.push      (push),
		.entry     (entry)
	);

	csvs_queue #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (csvs_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	csvs_back #(
		.OFFSET_WIDTH (OFFSET_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH),
		.ENTRY_WIDTH  (ENTRY_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.record_kind  (record_kind),
		.start_offset (start_offset),
		.end_offset   (end_offset),
		.cells_in_row (cells_in_row),
		.last         (last)
	);

endmodule

FILE: tb/csv_cell_row_boundary_scanner_tb.sv
// self-checking testbench for the csv cell and row boundary scanner
`timescale 1ns / 1ps

module csv_cell_row_boundary_scanner_tb;

	localparam int OFS_W          = 32;
	localparam int CNT_W          = 16;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_WORDS    = 120;

	typedef struct packed {
		logic             rec_kind;
		logic [OFS_W-1:0] start_ofs;
		logic [OFS_W-1:0] end_ofs;
		logic [CNT_W-1:0] cells;
		logic             last_flag;
	} boundary_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [csvs_pkg::INDEX_WIDTH-1:0] cfg_index;
	logic [csvs_pkg::CHAR_WIDTH-1:0]  cfg_data;
	logic                             in_valid;
	logic                             in_ready;
	logic                             kind;
	logic [csvs_pkg::CHAR_WIDTH-1:0]  data_byte;
	logic                             out_valid;
	logic                             out_ready;
	logic                             record_kind;
	logic [OFS_W-1:0]                 start_offset;
	logic [OFS_W-1:0]                 end_offset;
	logic [CNT_W-1:0]                 cells_in_row;
	logic                             last;

	// scanner state as seen by the predictor
	csvs_pkg::cfg_t   scan_cfg;
	logic [OFS_W-1:0] byte_pos;
	logic             escape_armed;
	logic             in_quotes;
	logic [OFS_W-1:0] cell_start;
	logic [OFS_W-1:0] row_start;
	logic [CNT_W-1:0] row_tally;

	boundary_t expected_boundaries[$];
	boundary_t want;

	int sender_idle_pct;
	int recv_stall_pct;
	int words_sent;
	int flush_words;
	int settings_loaded;
	int cell_records = 0;
	int row_records  = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;

	csv_cell_row_boundary_scanner #(
		.OFFSET_WIDTH(OFS_W),
		.COUNT_WIDTH (CNT_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.record_kind (record_kind),
		.start_offset(start_offset),
		.end_offset  (end_offset),
		.cells_in_row(cells_in_row),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CNT_W-1:0] tally_plus_one(input logic [CNT_W-1:0] t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	function automatic void push_boundary(input logic k, input logic [OFS_W-1:0] s,
			input logic [OFS_W-1:0] e, input logic [CNT_W-1:0] n);
		boundary_t b;
		b.rec_kind  = k;
		b.start_ofs = s;
		b.end_ofs   = e;
		b.cells     = n;
		b.last_flag = 1'b0;
		expected_boundaries.insert(expected_boundaries.size(), b);
	endfunction

	function automatic void predict_boundaries(input logic k, input logic [7:0] b);
		logic [OFS_W-1:0] pos;
		logic             consumed;
		int               first;
		pos      = byte_pos;
		first    = expected_boundaries.size();
		consumed = 1'b0;
		if (k == csvs_pkg::KIND_FLUSH) begin
			if (cell_start < pos && row_tally != 0) begin
				push_boundary(csvs_pkg::REC_CELL, cell_start, pos, '0);
				push_boundary(csvs_pkg::REC_ROW, row_start, pos, tally_plus_one(row_tally));
				row_tally  = '0;
				row_start  = pos;
				cell_start = pos;
			end
		end else begin
			if (scan_cfg.csv_mode) begin
				if (escape_armed) begin
					escape_armed = 1'b0;
					consumed     = 1'b1;
				end else if (in_quotes) begin
					if (b == scan_cfg.quote_char)
						in_quotes = 1'b0;
					consumed = 1'b1;
				end else begin
					if (b == scan_cfg.escape_char)
						escape_armed = 1'b1;
					if (b == scan_cfg.quote_char)
						in_quotes = 1'b1;
					if (b == scan_cfg.separator_char && b != scan_cfg.newline_char) begin
						push_boundary(csvs_pkg::REC_CELL, cell_start, pos, '0);
						row_tally  = tally_plus_one(row_tally);
						cell_start = pos + 1'b1;
					end
				end
			end
			if (!consumed && b == scan_cfg.newline_char) begin
				// empty lines give no records but still restart the row
				if (row_start != pos) begin
					push_boundary(csvs_pkg::REC_CELL, cell_start, pos, '0);
					push_boundary(csvs_pkg::REC_ROW, row_start, pos,
						tally_plus_one(row_tally));
				end
				row_tally  = '0;
				cell_start = pos + 1'b1;
				row_start  = pos + 1'b1;
			end
			byte_pos = pos + 1'b1;
		end
		if (expected_boundaries.size() > first)
			expected_boundaries[expected_boundaries.size()-1].last_flag = 1'b1;
	endfunction

	task automatic send_word(input logic k, input logic [7:0] b);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		data_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		predict_boundaries(k, b);
		words_sent++;
		if (k == csvs_pkg::KIND_FLUSH)
			flush_words++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(csvs_pkg::KIND_DATA, s[i]);
	endtask

	// wait until every record is out and any word without a record has passed
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_boundaries.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_registers(input csvs_pkg::cfg_t c);
		cfg_wr_en <= 1'b1;
		cfg_index <= csvs_pkg::REG_CSV_MODE;
		cfg_data  <= {7'd0, c.csv_mode};
		@(posedge clk);
		cfg_index <= csvs_pkg::REG_QUOTE;
		cfg_data  <= c.quote_char;
		@(posedge clk);
		cfg_index <= csvs_pkg::REG_ESCAPE;
		cfg_data  <= c.escape_char;
		@(posedge clk);
		cfg_index <= csvs_pkg::REG_SEPARATOR;
		cfg_data  <= c.separator_char;
		@(posedge clk);
		cfg_index <= csvs_pkg::REG_NEWLINE;
		cfg_data  <= c.newline_char;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		scan_cfg = c;
		settings_loaded++;
	endtask

	function automatic logic [7:0] text_byte(input bit quoted);
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == scan_cfg.quote_char || (!quoted && (b == scan_cfg.escape_char ||
			b == scan_cfg.separator_char || b == scan_cfg.newline_char)));
		return b;
	endfunction

	// mostly well-formed rows with random content, some noise and broken rows
	task automatic send_row();
		int ncells;
		int r;
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(12, 1))
				send_word(($urandom_range(99) < 5) ? csvs_pkg::KIND_FLUSH :
					csvs_pkg::KIND_DATA, 8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(99) < 8) begin
			send_word(csvs_pkg::KIND_DATA, scan_cfg.newline_char);
			return;
		end
		ncells = $urandom_range(5, 1);
		for (int c = 0; c < ncells; c++) begin
			if (c != 0)
				send_word(csvs_pkg::KIND_DATA, scan_cfg.separator_char);
			if ($urandom_range(99) < 25) begin
				send_word(csvs_pkg::KIND_DATA, scan_cfg.quote_char);
				repeat ($urandom_range(5)) begin
					if ($urandom_range(99) < 30)
						send_word(csvs_pkg::KIND_DATA, $urandom_range(1) ?
							scan_cfg.separator_char : scan_cfg.newline_char);
					else
						send_word(csvs_pkg::KIND_DATA, text_byte(1'b1));
				end
				send_word(csvs_pkg::KIND_DATA, scan_cfg.quote_char);
			end else begin
				repeat ($urandom_range(6)) begin
					if ($urandom_range(99) < 10) begin
						send_word(csvs_pkg::KIND_DATA, scan_cfg.escape_char);
						send_word(csvs_pkg::KIND_DATA, 8'($urandom_range(255)));
					end else
						send_word(csvs_pkg::KIND_DATA, text_byte(1'b0));
				end
			end
		end
		r = $urandom_range(99);
		if (r < 80)
			send_word(csvs_pkg::KIND_DATA, scan_cfg.newline_char);
		else if (r < 92)
			send_word(csvs_pkg::KIND_FLUSH, 8'($urandom_range(255)));
	endtask

	task automatic test_reset_defaults();
		send_text("a,b\n");
		send_text("\n");
		send_text("\",\n\"x\n");
		send_text("\\,y,");
		send_word(csvs_pkg::KIND_DATA, 8'h00);
		send_word(csvs_pkg::KIND_DATA, 8'hFF);
		send_word(csvs_pkg::KIND_FLUSH, 8'h00);
		send_word(csvs_pkg::KIND_FLUSH, 8'hFF);
		send_text("z");
		send_word(csvs_pkg::KIND_FLUSH, 8'h2C);
		send_text("\n");
	endtask

	task automatic test_shared_codes();
		settle();
		// quote doubles as escape, separator doubles as newline
		load_registers('{csv_mode: 1'b1, quote_char: 8'h27, escape_char: 8'h27,
			separator_char: 8'h3B, newline_char: 8'h3B});
		send_text("a;b'c;d';");
		send_word(csvs_pkg::KIND_FLUSH, 8'h00);
		settle();
		load_registers('{csv_mode: 1'b1, quote_char: 8'h22, escape_char: 8'h2C,
			separator_char: 8'h2C, newline_char: 8'h0A});
		send_text("x,y,\n");
		settle();
		load_registers('{csv_mode: 1'b1, quote_char: 8'h0A, escape_char: 8'h5C,
			separator_char: 8'h2C, newline_char: 8'h0A});
		send_text("p\nq,r\n");
	endtask

	task automatic test_line_mode();
		csvs_pkg::cfg_t csv_cfg;
		csvs_pkg::cfg_t line_cfg;
		csv_cfg  = '{csv_mode: 1'b1, quote_char: csvs_pkg::RESET_QUOTE,
			escape_char: csvs_pkg::RESET_ESCAPE, separator_char: csvs_pkg::RESET_SEPARATOR,
			newline_char: csvs_pkg::RESET_NEWLINE};
		line_cfg = csv_cfg;
		line_cfg.csv_mode = 1'b0;
		settle();
		load_registers(line_cfg);
		send_text("\"a,\n\\\n\nb");
		send_word(csvs_pkg::KIND_FLUSH, 8'h00);
		send_text("\n");
		// quote state carried across mode changes
		settle();
		load_registers(csv_cfg);
		send_text("\"q");
		settle();
		load_registers(line_cfg);
		send_text("x\n");
		settle();
		load_registers(csv_cfg);
		send_text(",\"\n");
		send_word(csvs_pkg::KIND_FLUSH, 8'h00);
	endtask

	task automatic test_random_traffic();
		csvs_pkg::cfg_t plan[8];
		int             idle_plan[4];
		int             stall_plan[4];
		int             target;
		idle_plan  = '{0, 86, 0, 30};
		stall_plan = '{0, 0, 86, 30};
		plan[0] = '{csv_mode: 1'b1, quote_char: csvs_pkg::RESET_QUOTE,
			escape_char: csvs_pkg::RESET_ESCAPE, separator_char: csvs_pkg::RESET_SEPARATOR,
			newline_char: csvs_pkg::RESET_NEWLINE};
		plan[1] = '{csv_mode: 1'b1, quote_char: 8'h00, escape_char: 8'hFF,
			separator_char: 8'h01, newline_char: 8'hFE};
		plan[2] = '{csv_mode: 1'b1, quote_char: 8'hFF, escape_char: 8'h00,
			separator_char: 8'hFE, newline_char: 8'h01};
		plan[3] = '{csv_mode: 1'b0, quote_char: csvs_pkg::RESET_QUOTE,
			escape_char: csvs_pkg::RESET_ESCAPE, separator_char: csvs_pkg::RESET_SEPARATOR,
			newline_char: csvs_pkg::RESET_NEWLINE};
		plan[4] = '{csv_mode: 1'b1, quote_char: 8'h27, escape_char: 8'h27,
			separator_char: 8'h3B, newline_char: 8'h0D};
		plan[5] = '{csv_mode: 1'b1, quote_char: 8'h7C, escape_char: 8'h5C,
			separator_char: 8'h0A, newline_char: 8'h0A};
		plan[6] = '{csv_mode: 1'b1, quote_char: 8'($urandom_range(255)),
			escape_char: 8'($urandom_range(255)), separator_char: 8'($urandom_range(255)),
			newline_char: 8'($urandom_range(255))};
		plan[7] = '{csv_mode: 1'b0, quote_char: 8'($urandom_range(255)),
			escape_char: 8'($urandom_range(255)), separator_char: 8'($urandom_range(255)),
			newline_char: 8'($urandom_range(255))};
		for (int p = 0; p < 8; p++) begin
			settle();
			load_registers(plan[p]);
			sender_idle_pct = idle_plan[p % 4];
			recv_stall_pct  = stall_plan[p % 4];
			target = words_sent + PHASE_WORDS;
			while (words_sent < target)
				send_row();
		end
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
	endtask

	always @(posedge clk)
		out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (record_kind == csvs_pkg::REC_CELL)
				cell_records++;
			else
				row_records++;
			if (expected_boundaries.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected record: kind %0d start %0d end %0d cells %0d last %0d",
						record_kind, start_offset, end_offset, cells_in_row, last);
				mismatches++;
			end else begin
				want = expected_boundaries.pop_front();
				if (record_kind !== want.rec_kind || start_offset !== want.start_ofs ||
						end_offset !== want.end_ofs || cells_in_row !== want.cells ||
						last !== want.last_flag) begin
					if (mismatches < 10) begin
						$display("mismatch: expected kind %0d start %0d end %0d cells %0d last %0d",
							want.rec_kind, want.start_ofs, want.end_ofs, want.cells,
							want.last_flag);
						$display("          got      kind %0d start %0d end %0d cells %0d last %0d",
							record_kind, start_offset, end_offset, cells_in_row, last);
					end
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("** csv_cell_row_boundary_scanner: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		kind            = csvs_pkg::KIND_DATA;
		data_byte       = '0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		words_sent      = 0;
		flush_words     = 0;
		settings_loaded = 0;
		scan_cfg = '{csv_mode: 1'b1, quote_char: csvs_pkg::RESET_QUOTE,
			escape_char: csvs_pkg::RESET_ESCAPE, separator_char: csvs_pkg::RESET_SEPARATOR,
			newline_char: csvs_pkg::RESET_NEWLINE};
		byte_pos     = '0;
		escape_armed = 1'b0;
		in_quotes    = 1'b0;
		cell_start   = '0;
		row_start    = '0;
		row_tally    = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_shared_codes();
		test_line_mode();
		test_random_traffic();
		settle();

		$display("summary: %0d words (%0d flushes) under %0d register settings, four idle mixes",
			words_sent, flush_words, settings_loaded);
		$display("summary: %0d cell and %0d row records checked, %0d mismatches",
			cell_records, row_records, mismatches);
		if (mismatches == 0)
			$display("** csv_cell_row_boundary_scanner: PASSED **");
		else
			$display("** csv_cell_row_boundary_scanner: FAILED **");
		$finish;
	end

endmodule

FILE: csv_cell_row_boundary_scanner.f
rtl/csvs_pkg.sv
rtl/csvs_front.sv
rtl/csvs_queue.sv
rtl/csvs_back.sv
rtl/csv_cell_row_boundary_scanner.sv
tb/csv_cell_row_boundary_scanner_tb.sv
